// File: hw/rtl/mbd_pkg.sv
// Shared types and constants for the mask boundary min-distance block.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package mbd_pkg;

  localparam int LABEL_W = 8;
  localparam int ENTRY_W = LABEL_W + 1;
  localparam int DIST_W  = 20;
  localparam int CFG_W   = 7;

  localparam logic [DIST_W-1:0] NO_BOUNDARY = 20'd1000000;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_WINDOW_WIDTH  = 1'b0;
  localparam logic REG_WINDOW_HEIGHT = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
  } scan_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [DIST_W-1:0] sq_dist;
  } dist_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/mbd_patch_mem.sv
// Label patch storage: two copies of the patch, one read twice per cycle
// (rows above and below), one read once (center row). Uses mbd_pkg.
`default_nettype none

module mbd_patch_mem #(
  parameter int DEPTH = 4356,
  parameter int AW    = 13
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [mbd_pkg::ENTRY_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr_up,
  input  wire logic [AW-1:0]            raddr_ctr,
  input  wire logic [AW-1:0]            raddr_dn,
  output logic [mbd_pkg::ENTRY_W-1:0]   rdata_up_r,
  output logic [mbd_pkg::ENTRY_W-1:0]   rdata_ctr_r,
  output logic [mbd_pkg::ENTRY_W-1:0]   rdata_dn_r
);

  logic [mbd_pkg::ENTRY_W-1:0] mem_ud [DEPTH];
  logic [mbd_pkg::ENTRY_W-1:0] mem_c  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_ud[waddr] <= wdata;
      mem_c[waddr]  <= wdata;
    end
    rdata_up_r  <= mem_ud[raddr_up];
    rdata_dn_r  <= mem_ud[raddr_dn];
    rdata_ctr_r <= mem_c[raddr_ctr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbd_scan.sv
// Raster scan sequencer: walks window rows and patch columns, one patch
// column per cycle, and issues the three row addresses. Uses mbd_pkg.
`default_nettype none

module mbd_scan #(
  parameter int PS = 66,
  parameter int AW = 13,
  parameter int RW = 6,
  parameter int PW = 7,
  parameter int DW = 7
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           go,
  input  wire logic [DW-1:0]  w_eff,
  input  wire logic [DW-1:0]  h_eff,
  output mbd_pkg::scan_ctl_t  ctl,
  output logic [RW-1:0]       row,
  output logic [PW-1:0]       pc,
  output logic [AW-1:0]       addr_up,
  output logic [AW-1:0]       addr_ctr,
  output logic [AW-1:0]       addr_dn
);

  logic          active_r;
  logic [RW-1:0] row_r;
  logic [PW-1:0] pc_r;
  logic [AW-1:0] base_r;
  logic          row_end;
  logic          last;

  assign row_end = (pc_r == PW'(w_eff) + PW'(1));
  assign last    = row_end && (int'(row_r) == int'(h_eff) - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (go) begin
      active_r <= 1'b1;
    end else if (active_r && last) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      row_r  <= '0;
      pc_r   <= '0;
      base_r <= '0;
    end else if (active_r) begin
      if (row_end) begin
        pc_r   <= '0;
        row_r  <= row_r + RW'(1);
        base_r <= base_r + AW'(PS);
      end else begin
        pc_r <= pc_r + PW'(1);
      end
    end
  end

  assign ctl.valid = active_r;
  assign ctl.last  = last;
  assign row       = row_r;
  assign pc        = pc_r;
  assign addr_up   = base_r + AW'(pc_r);
  assign addr_ctr  = base_r + AW'(PS) + AW'(pc_r);
  assign addr_dn   = base_r + AW'(2 * PS) + AW'(pc_r);

endmodule

`default_nettype wire

// File: hw/rtl/mbd_eval.sv
// Boundary test on the four direct neighbors in a 3x3 window, squared distance and
// running minimum. Fed by mbd_scan tags and mbd_patch_mem data. Uses mbd_pkg.
`default_nettype none

module mbd_eval #(
  parameter int RW = 6,
  parameter int PW = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        clear,
  input  wire logic [5:0]                  query_row,
  input  wire logic [5:0]                  query_col,
  input  wire mbd_pkg::scan_ctl_t          ctl_in,
  input  wire logic [RW-1:0]               row_in,
  input  wire logic [PW-1:0]               pc_in,
  input  wire logic [mbd_pkg::ENTRY_W-1:0] rd_up,
  input  wire logic [mbd_pkg::ENTRY_W-1:0] rd_ctr,
  input  wire logic [mbd_pkg::ENTRY_W-1:0] rd_dn,
  output mbd_pkg::dist_res_t               res
);

  localparam int XW = (RW > 6) ? RW : 6;
  localparam int SW = 2 * XW + 1;

  logic [5:0] qrow_r, qcol_r;

  mbd_pkg::scan_ctl_t ctl1_r, ctl2_r;
  logic [RW-1:0]      row1_r, row2_r;
  logic [PW-1:0]      pc1_r, pc2_r;

  logic [mbd_pkg::ENTRY_W-1:0] ctr0_r, ctr1_r, ctr2_r;
  logic [mbd_pkg::ENTRY_W-1:0] up0_r, up1_r, dn0_r, dn1_r;

  logic              eval_ok, bnd;
  logic [RW-1:0]     wcol;
  logic [XW-1:0]     ra, rb, ca, cb, dr, dc;

  logic              bnd3_r, last3_r, bnd4_r, last4_r;
  logic [XW-1:0]     dr3_r, dc3_r;
  logic [2*XW-1:0]   sqr4_r, sqc4_r;

  logic [SW-1:0]             dsum;
  logic [mbd_pkg::DIST_W-1:0] d;
  logic                      better;
  logic [mbd_pkg::DIST_W-1:0] best_r;
  logic                      found_r;

  function automatic logic differs(input logic [mbd_pkg::ENTRY_W-1:0] nb,
                                   input logic [mbd_pkg::LABEL_W-1:0] lab);
    differs = nb[mbd_pkg::ENTRY_W-1] && (nb[mbd_pkg::LABEL_W-1:0] != lab);
  endfunction

  always_ff @(posedge clk) begin
    if (clear) begin
      qrow_r <= query_row;
      qcol_r <= query_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      bnd3_r  <= 1'b0;
      last3_r <= 1'b0;
      bnd4_r  <= 1'b0;
      last4_r <= 1'b0;
    end else begin
      ctl1_r  <= ctl_in;
      ctl2_r  <= ctl1_r;
      bnd3_r  <= eval_ok && bnd;
      last3_r <= ctl2_r.valid && ctl2_r.last;
      bnd4_r  <= bnd3_r;
      last4_r <= last3_r;
    end
  end

  // data path: tag align, column shift, abs diff, squares
  always_ff @(posedge clk) begin
    row1_r <= row_in;
    pc1_r  <= pc_in;
    row2_r <= row1_r;
    pc2_r  <= pc1_r;
    ctr0_r <= rd_ctr;
    ctr1_r <= ctr0_r;
    ctr2_r <= ctr1_r;
    up0_r  <= rd_up;
    up1_r  <= up0_r;
    dn0_r  <= rd_dn;
    dn1_r  <= dn0_r;
    dr3_r  <= dr;
    dc3_r  <= dc;
    sqr4_r <= (2*XW)'(dr3_r) * (2*XW)'(dr3_r);
    sqc4_r <= (2*XW)'(dc3_r) * (2*XW)'(dc3_r);
  end

  // pixel under test is the middle column of the shift window
  assign eval_ok = ctl2_r.valid && (pc2_r >= PW'(2));
  assign bnd     = (ctr1_r[mbd_pkg::LABEL_W-1:0] != '0) &&
                   (differs(ctr2_r, ctr1_r[mbd_pkg::LABEL_W-1:0]) ||
                    differs(ctr0_r, ctr1_r[mbd_pkg::LABEL_W-1:0]) ||
                    differs(up1_r,  ctr1_r[mbd_pkg::LABEL_W-1:0]) ||
                    differs(dn1_r,  ctr1_r[mbd_pkg::LABEL_W-1:0]));
  assign wcol    = RW'(pc2_r - PW'(2));

  assign ra = XW'(row2_r);
  assign rb = XW'(qrow_r);
  assign ca = XW'(wcol);
  assign cb = XW'(qcol_r);
  assign dr = (ra > rb) ? ra - rb : rb - ra;
  assign dc = (ca > cb) ? ca - cb : cb - ca;

  assign dsum   = SW'(sqr4_r) + SW'(sqc4_r);
  assign d      = mbd_pkg::DIST_W'(dsum);
  assign better = bnd4_r && (d < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      best_r  <= mbd_pkg::NO_BOUNDARY;
      found_r <= 1'b0;
    end else if (bnd4_r) begin
      found_r <= 1'b1;
      if (better) begin
        best_r <= d;
      end
    end
  end

  assign res.valid   = last4_r;
  assign res.found   = found_r || bnd4_r;
  assign res.sq_dist = better ? d : best_r;

endmodule

`default_nettype wire

// File: hw/rtl/mask_boundary_min_distance.sv
// Nearest boundary squared distance over a label patch held in memory.
// Load: written on acceptance, busy stays low. Query: scans h window rows of w+2
// patch columns, one patch column per cycle through the three-row memory read, then
// the evaluation pipeline; busy drops as the result shows, so the next transfer can
// follow at once. An empty window answers in the cycle after the transfer.
// Sync active-low reset clears control and sets both window registers to 64;
// patch contents are undefined until loaded. Results cannot be stalled.
`default_nettype none

module mask_boundary_min_distance #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [6:0]  in_patch_row,
  input  wire logic [6:0]  in_patch_col,
  input  wire logic [7:0]  in_label_value,
  input  wire logic        in_in_image,
  input  wire logic [5:0]  in_query_row,
  input  wire logic [5:0]  in_query_col,
  output logic             out_valid,
  output logic [19:0]      out_min_sq_distance,
  output logic             out_found,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [6:0]  cfg_wdata
);

  localparam int PS = MAX_WINDOW + 2;
  localparam int AW = $clog2(PS * PS);
  localparam int PW = $clog2(PS);
  localparam int RW = $clog2(MAX_WINDOW);
  localparam int DW = $clog2(MAX_WINDOW + 1);

  logic [mbd_pkg::CFG_W-1:0] width_r, height_r;
  logic [DW-1:0]             w_eff, h_eff;
  logic                      busy_r;
  logic                      accept, load_ok, query_go, empty, scan_go;
  logic [AW-1:0]             waddr;
  logic [mbd_pkg::ENTRY_W-1:0] wdata;

  mbd_pkg::scan_ctl_t        scan_ctl;
  logic [RW-1:0]             scan_row;
  logic [PW-1:0]             scan_pc;
  logic [AW-1:0]             addr_up, addr_ctr, addr_dn;
  logic [mbd_pkg::ENTRY_W-1:0] rd_up, rd_ctr, rd_dn;
  mbd_pkg::dist_res_t        res;

  logic                      out_valid_r, out_found_r;
  logic [mbd_pkg::DIST_W-1:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mbd_pkg::CFG_W'(64);
      height_r <= mbd_pkg::CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index[0])
        mbd_pkg::REG_WINDOW_WIDTH:  width_r  <= cfg_wdata;
        mbd_pkg::REG_WINDOW_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_eff = (int'(width_r) > MAX_WINDOW)  ? DW'(MAX_WINDOW) : DW'(width_r);
  assign h_eff = (int'(height_r) > MAX_WINDOW) ? DW'(MAX_WINDOW) : DW'(height_r);

  assign accept   = start && !busy_r;
  assign load_ok  = accept && (in_kind == mbd_pkg::KIND_LOAD) &&
                    (int'(in_patch_row) < PS) && (int'(in_patch_col) < PS);
  assign query_go = accept && (in_kind == mbd_pkg::KIND_QUERY);
  assign empty    = (w_eff == '0) || (h_eff == '0);
  assign scan_go  = query_go && !empty;

  assign waddr = AW'(in_patch_row) * AW'(PS) + AW'(in_patch_col);
  assign wdata = {in_in_image, in_label_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (scan_go) begin
      busy_r <= 1'b1;
    end else if (res.valid) begin
      busy_r <= 1'b0;
    end
  end

  mbd_patch_mem #(
    .DEPTH (PS * PS),
    .AW    (AW)
  ) u_mem (
    .clk         (clk),
    .we          (load_ok),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr_up    (addr_up),
    .raddr_ctr   (addr_ctr),
    .raddr_dn    (addr_dn),
    .rdata_up_r  (rd_up),
    .rdata_ctr_r (rd_ctr),
    .rdata_dn_r  (rd_dn)
  );

  mbd_scan #(
    .PS (PS),
    .AW (AW),
    .RW (RW),
    .PW (PW),
    .DW (DW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (scan_go),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .ctl      (scan_ctl),
    .row      (scan_row),
    .pc       (scan_pc),
    .addr_up  (addr_up),
    .addr_ctr (addr_ctr),
    .addr_dn  (addr_dn)
  );

  mbd_eval #(
    .RW (RW),
    .PW (PW)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (query_go),
    .query_row (in_query_row),
    .query_col (in_query_col),
    .ctl_in    (scan_ctl),
    .row_in    (scan_row),
    .pc_in     (scan_pc),
    .rd_up     (rd_up),
    .rd_ctr    (rd_ctr),
    .rd_dn     (rd_dn),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (query_go && empty) || res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (query_go && empty) begin
      out_dist_r  <= mbd_pkg::NO_BOUNDARY;
      out_found_r <= 1'b0;
    end else if (res.valid) begin
      out_dist_r  <= res.sq_dist;
      out_found_r <= res.found;
    end
  end

  assign busy                = busy_r;
  assign out_valid           = out_valid_r;
  assign out_min_sq_distance = out_dist_r;
  assign out_found           = out_found_r;

endmodule

`default_nettype wire

// File: tb/sv/mask_boundary_min_distance_test.sv
// Self-checking testbench for mask_boundary_min_distance: loads label patches,
// issues distance queries and compares each result with an in-bench predictor.
// Depends on mbd_pkg and the mask_boundary_min_distance RTL only.
`timescale 1ns / 100ps

module mask_boundary_min_distance_test;

  localparam int PATCH_SIDE = 66;
  localparam int WIN_MAX    = 64;
  localparam int SMALL_WIN  = 6;
  localparam int PRELOAD    = SMALL_WIN + 2;

  typedef struct {
    logic                        kind;
    logic [6:0]                  patch_row;
    logic [6:0]                  patch_col;
    logic [mbd_pkg::LABEL_W-1:0] label_value;
    logic                        in_image;
    logic [5:0]                  query_row;
    logic [5:0]                  query_col;
  } patch_cmd_t;

  typedef struct {
    logic [mbd_pkg::DIST_W-1:0] sq_dist;
    logic                       found;
  } dist_exp_t;

  class boundary_scoreboard;
    logic [mbd_pkg::ENTRY_W-1:0] patch [PATCH_SIDE*PATCH_SIDE];
    logic [mbd_pkg::CFG_W-1:0]   win_w;
    logic [mbd_pkg::CFG_W-1:0]   win_h;
    dist_exp_t                   pending [$];
    int                          errors;

    function new();
      foreach (patch[i]) patch[i] = '0;
      win_w  = 7'd64;
      win_h  = 7'd64;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [mbd_pkg::CFG_W-1:0] val);
      if (idx == mbd_pkg::REG_WINDOW_WIDTH) win_w = val;
      else win_h = val;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void note_input(patch_cmd_t it);
      int        w;
      int        h;
      int        best;
      int        pr;
      int        pc;
      int        dr;
      int        dc;
      int        d;
      int        nb_idx [4];
      logic      bnd;
      logic      fnd;
      dist_exp_t e;
      if (it.kind == mbd_pkg::KIND_LOAD) begin
        if (it.patch_row < PATCH_SIDE && it.patch_col < PATCH_SIDE)
          patch[it.patch_row*PATCH_SIDE + it.patch_col] = {it.in_image, it.label_value};
        return;
      end
      w = (win_w > WIN_MAX) ? WIN_MAX : win_w;
      h = (win_h > WIN_MAX) ? WIN_MAX : win_h;
      best = mbd_pkg::NO_BOUNDARY;
      fnd = 1'b0;
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          pr = r + 1;
          pc = c + 1;
          if (patch[pr*PATCH_SIDE + pc][mbd_pkg::LABEL_W-1:0] != '0) begin
            nb_idx[0] = (pr + 1)*PATCH_SIDE + pc;
            nb_idx[1] = pr*PATCH_SIDE + pc + 1;
            nb_idx[2] = (pr - 1)*PATCH_SIDE + pc;
            nb_idx[3] = pr*PATCH_SIDE + pc - 1;
            bnd = 1'b0;
            for (int k = 0; k < 4; k++)
              if (patch[nb_idx[k]][mbd_pkg::LABEL_W] &&
                  patch[nb_idx[k]][mbd_pkg::LABEL_W-1:0] !=
                  patch[pr*PATCH_SIDE + pc][mbd_pkg::LABEL_W-1:0])
                bnd = 1'b1;
            if (bnd) begin
              dr = (r > it.query_row) ? r - it.query_row : it.query_row - r;
              dc = (c > it.query_col) ? c - it.query_col : it.query_col - c;
              d = dr*dr + dc*dc;
              fnd = 1'b1;
              if (d < best) best = d;
            end
          end
        end
      end
      e.sq_dist = best[mbd_pkg::DIST_W-1:0];
      e.found   = fnd;
      pending.insert(pending.size(), e);
    endfunction

    function void check(logic [mbd_pkg::DIST_W-1:0] sq_dist, logic found);
      dist_exp_t e;
      if (pending.size() == 0) begin
        $error("result with no query waiting: min_sq_distance %0d found %0d",
               sq_dist, found);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (sq_dist !== e.sq_dist) begin
        $error("min_sq_distance: expected %0d, actual %0d", e.sq_dist, sq_dist);
        errors++;
      end
      if (found !== e.found) begin
        $error("found: expected %0d, actual %0d", e.found, found);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_kind = mbd_pkg::KIND_LOAD;
  logic [6:0]         in_patch_row = '0;
  logic [6:0]         in_patch_col = '0;
  logic [7:0]         in_label_value = '0;
  logic               in_in_image = 1'b0;
  logic [5:0]         in_query_row = '0;
  logic [5:0]         in_query_col = '0;
  logic               out_valid;
  logic [19:0]        out_min_sq_distance;
  logic               out_found;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = mbd_pkg::REG_WINDOW_WIDTH;
  logic [6:0]         cfg_wdata = '0;

  boundary_scoreboard sb = new();
  int                 idle_pct = 0;

  mask_boundary_min_distance uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_patch_row        (in_patch_row),
    .in_patch_col        (in_patch_col),
    .in_label_value      (in_label_value),
    .in_in_image         (in_in_image),
    .in_query_row        (in_query_row),
    .in_query_col        (in_query_col),
    .out_valid           (out_valid),
    .out_min_sq_distance (out_min_sq_distance),
    .out_found           (out_found),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_min_sq_distance, out_found);
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic patch_cmd_t rand_cmd();
    patch_cmd_t it;
    it.kind        = 1'($urandom_range(0, 1));
    it.patch_row   = 7'($urandom_range(0, 127));
    it.patch_col   = 7'($urandom_range(0, 127));
    it.label_value = 8'($urandom_range(0, 255));
    it.in_image    = 1'($urandom_range(0, 1));
    it.query_row   = 6'($urandom_range(0, 63));
    it.query_col   = 6'($urandom_range(0, 63));
    return it;
  endfunction

  // mostly background with a few labels, so boundaries stay sparse
  function automatic logic [7:0] sparse_label();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 8'd0;
    if (roll < 80) return 8'd1;
    if (roll < 92) return 8'd2;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_in_image();
    return $urandom_range(0, 99) < 85;
  endfunction

  task automatic send(input patch_cmd_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_kind        <= it.kind;
    in_patch_row   <= it.patch_row;
    in_patch_col   <= it.patch_col;
    in_label_value <= it.label_value;
    in_in_image    <= it.in_image;
    in_query_row   <= it.query_row;
    in_query_col   <= it.query_col;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  task automatic load_px(input int row, input int col, input logic [7:0] lab,
                         input logic img);
    patch_cmd_t it;
    it             = rand_cmd();
    it.kind        = mbd_pkg::KIND_LOAD;
    it.patch_row   = 7'(row);
    it.patch_col   = 7'(col);
    it.label_value = lab;
    it.in_image    = img;
    send(it);
  endtask

  task automatic query(input int qr, input int qc);
    patch_cmd_t it;
    it           = rand_cmd();
    it.kind      = mbd_pkg::KIND_QUERY;
    it.query_row = 6'(qr);
    it.query_col = 6'(qc);
    send(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.outstanding() > 0 || busy) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_window(input logic [6:0] w, input logic [6:0] h);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= mbd_pkg::REG_WINDOW_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    sb.write_reg(mbd_pkg::REG_WINDOW_WIDTH, w);
    cfg_index <= mbd_pkg::REG_WINDOW_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    sb.write_reg(mbd_pkg::REG_WINDOW_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int         pcts [4];
    int         roll;
    int         ew;
    int         eh;
    logic [6:0] w;
    logic [6:0] h;
    patch_cmd_t it;

    pcts = '{0, 62, 0, 21};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // patch corner covered by the small windows defined up front
    for (int r = 0; r < PRELOAD; r++)
      for (int c = 0; c < PRELOAD; c++)
        load_px(r, c, sparse_label(), rand_in_image());

    // directed cases on a 1x1 window
    set_window(7'd1, 7'd1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        load_px(r, c, 8'd4, 1'b1);
    query(0, 0);
    query(63, 63);
    load_px(0, 1, 8'd9, 1'b0);                 // differing neighbor outside image
    query(0, 0);
    load_px(1, 1, 8'd4, 1'b0);                 // center flag clear, still counts
    load_px(0, 1, 8'd9, 1'b1);
    query(63, 63);
    query(0, 0);
    load_px(1, 1, 8'd0, 1'b1);                 // background center
    query(5, 5);
    load_px(1, 1, 8'd255, 1'b1);
    load_px(66, 1, 8'd0, 1'b1);                // out-of-range loads are dropped
    load_px(127, 127, 8'd0, 1'b0);
    load_px(1, 100, 8'd0, 1'b1);
    query(2, 40);
    set_window(7'd0, 7'd1);                    // empty window
    query(0, 0);
    set_window(7'd1, 7'd0);
    query(10, 10);

    // random phases on small windows
    for (int p = 0; p < 8; p++) begin
      idle_pct = pcts[p % 4];
      roll = $urandom_range(0, 99);
      w = (roll < 6) ? 7'd0 : 7'($urandom_range(1, SMALL_WIN));
      roll = $urandom_range(0, 99);
      h = (roll < 6) ? 7'd0 : 7'($urandom_range(1, SMALL_WIN));
      set_window(w, h);
      ew = w;
      eh = h;
      for (int i = 0; i < 6; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          load_px($urandom_range(0, eh + 1), $urandom_range(0, ew + 1),
                  sparse_label(), rand_in_image());
        end else if (roll < 60) begin
          it = rand_cmd();
          it.kind = mbd_pkg::KIND_LOAD;
          send(it);
        end else begin
          it = rand_cmd();
          it.kind = mbd_pkg::KIND_QUERY;
          send(it);
        end
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
